### rtl/core/kqsb_pkg.sv
package kqsb_pkg;

	localparam int NUM_SLOTS  = 16;
	localparam int NUM_QUEUES = 4;

	localparam int DATA_W = 32;
	localparam int QID_W  = 2;
	localparam int STAT_W = 2;

	// A slot pointer must also hold the null value, which is NUM_SLOTS.
	localparam int SLOT_W = $clog2(NUM_SLOTS + 1);
	localparam int SIDX_W = $clog2(NUM_SLOTS);
	localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

	localparam logic [SLOT_W-1:0] NIL = SLOT_W'(NUM_SLOTS);

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVF = 2'd1;
	localparam logic [STAT_W-1:0] ST_UDF = 2'd2;

	typedef struct packed {
		logic capture;
		logic exec;
		logic finish;
	} kqsb_cmd_t;

endpackage

### rtl/core/k_queues_shared_buffer.sv
// Several FIFO queues share one store of slots, chained through per-slot links
// and a free list. A request on the slave stream is an enqueue or a dequeue for
// one queue; every request gives exactly one result on the master stream:
// status ok, overflow (no free slot or no such queue, data 0) or underflow
// (empty or no such queue, data all ones). A request has an execute cycle
// that reads the link of the free head or queue head and updates the
// pointers, and a finish cycle that writes the second link of an enqueue
// and loads the output register. A new request can be taken in the finish
// cycle of the previous one while the master side keeps taking results; a
// held result stalls the next request only at its finish cycle.
module k_queues_shared_buffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data_in
	input  logic [2:0]  s_tuser,   // [0] req_type, [2:1] queue_id
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data_out
	output logic [1:0]  m_tuser    // [1:0] status
);
	import kqsb_pkg::*;

	kqsb_cmd_t                cmd;
	logic signed [DATA_W-1:0] data_out;
	logic [STAT_W-1:0]        status;

	kqsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	kqsb_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_type (s_tuser[0]),
		.queue_id (s_tuser[2:1]),
		.data_in  (s_tdata),
		.data_out (data_out),
		.status   (status)
	);

	assign m_tdata = data_out;
	assign m_tuser = status;

endmodule

### rtl/core/kqsb_ctrl.sv
module kqsb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output kqsb_pkg::kqsb_cmd_t cmd
);
	import kqsb_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !m_tvalid_q || m_tready;
	// A new request may enter in the same cycle the previous one finishes.
	assign s_tready = (state_q == S_IDLE) || ((state_q == S_FINISH) && out_free);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	assign cmd.capture = accept;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.finish  = (state_q == S_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= accept ? S_EXEC : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/kqsb_dpath.sv
module kqsb_dpath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  kqsb_pkg::kqsb_cmd_t                     cmd,
	input  logic                                    req_type,
	input  logic [kqsb_pkg::QID_W-1:0]              queue_id,
	input  logic signed [kqsb_pkg::DATA_W-1:0]      data_in,
	output logic signed [kqsb_pkg::DATA_W-1:0]      data_out,
	output logic [kqsb_pkg::STAT_W-1:0]             status
);
	import kqsb_pkg::*;

	// Captured request.
	logic              req_q;
	logic [QID_W-1:0]  qid_q;
	logic [DATA_W-1:0] din_q;

	// Queue pointers and free list head.
	logic [SLOT_W-1:0] head_q [NUM_QUEUES];
	logic [SLOT_W-1:0] tail_q [NUM_QUEUES];
	logic [SLOT_W-1:0] free_q;

	// Link store; an entry not yet written reads as its reset link i+1.
	logic [SLOT_W-1:0]    link_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] link_vld_q;

	logic [DATA_W-1:0] data_mem [NUM_SLOTS];
	logic [DATA_W-1:0] rd_data_q;

	logic [SLOT_W-1:0] slot_q;
	logic              fix_q;
	logic [STAT_W-1:0] stat_q;

	logic [QIDX_W-1:0] qi;
	logic              qvalid;
	logic [SLOT_W-1:0] hd;
	logic [SLOT_W-1:0] tl;
	logic              enq_ok;
	logic              deq_ok;
	logic [SLOT_W-1:0] rd_addr;
	logic [SIDX_W-1:0] ridx;
	logic [SLOT_W-1:0] link_rd;

	logic              lw_en;
	logic [SIDX_W-1:0] lw_idx;
	logic [SLOT_W-1:0] lw_val;

	assign qi     = QIDX_W'(qid_q);
	assign qvalid = (32'(qid_q) < 32'(NUM_QUEUES));
	assign hd     = head_q[qi];
	assign tl     = tail_q[qi];
	assign enq_ok = (req_q == REQ_ENQ) && qvalid && (32'(free_q) < 32'(NUM_SLOTS));
	assign deq_ok = (req_q == REQ_DEQ) && qvalid && (32'(hd) < 32'(NUM_SLOTS));

	assign rd_addr = (req_q == REQ_ENQ) ? free_q : hd;
	assign ridx    = rd_addr[SIDX_W-1:0];
	assign link_rd = link_vld_q[ridx] ? link_q[ridx] : (SLOT_W'(ridx) + SLOT_W'(1));

	// The link store takes one write a cycle: a tail link or a freed slot in the
	// execute cycle, the null link of a newly filled slot in the finish cycle.
	always_comb begin
		lw_en  = 1'b0;
		lw_idx = free_q[SIDX_W-1:0];
		lw_val = NIL;
		if (cmd.exec && enq_ok && (32'(hd) < 32'(NUM_SLOTS))
				&& (32'(tl) < 32'(NUM_SLOTS))) begin
			lw_en  = 1'b1;
			lw_idx = tl[SIDX_W-1:0];
			lw_val = free_q;
		end else if (cmd.exec && deq_ok) begin
			lw_en  = 1'b1;
			lw_idx = hd[SIDX_W-1:0];
			lw_val = free_q;
		end else if (cmd.finish && fix_q) begin
			lw_en  = 1'b1;
			lw_idx = slot_q[SIDX_W-1:0];
			lw_val = NIL;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			qid_q <= queue_id;
			din_q <= data_in;
		end
		if (lw_en) begin
			link_q[lw_idx] <= lw_val;
		end
		if (cmd.exec) begin
			slot_q <= free_q;
			stat_q <= (req_q == REQ_ENQ) ? (enq_ok ? ST_OK : ST_OVF)
			                             : (deq_ok ? ST_OK : ST_UDF);
		end
		if (cmd.finish) begin
			status <= stat_q;
			if (stat_q == ST_UDF) begin
				data_out <= '1;
			end else if (req_q == REQ_DEQ) begin
				data_out <= rd_data_q;
			end else begin
				data_out <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) begin
			data_mem[free_q[SIDX_W-1:0]] <= din_q;
		end
		if (cmd.exec) begin
			rd_data_q <= data_mem[hd[SIDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
			free_q     <= '0;
			link_vld_q <= '0;
			fix_q      <= 1'b0;
		end else begin
			if (lw_en) begin
				link_vld_q[lw_idx] <= 1'b1;
			end
			if (cmd.exec) begin
				fix_q <= enq_ok;
				if (enq_ok) begin
					free_q     <= link_rd;
					tail_q[qi] <= free_q;
					if (!(32'(hd) < 32'(NUM_SLOTS))) begin
						head_q[qi] <= free_q;
					end
				end else if (deq_ok) begin
					head_q[qi] <= link_rd;
					free_q     <= hd;
				end
			end
		end
	end

endmodule

### rtl/core/kqsb_chk.sv
module kqsb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import kqsb_pkg::*;

	// A held result must not change until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Each request executes before the next is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted during execute");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_OVF) || (m_tuser == ST_UDF))
		else $error("invalid status code");

	a_udf_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_UDF) |-> (m_tdata == '1))
		else $error("underflow result is not all ones");

	a_ovf_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_OVF) |-> (m_tdata == '0))
		else $error("overflow result is not zero");

endmodule

bind k_queues_shared_buffer kqsb_chk u_kqsb_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
